// ===== rtl/mstk_pkg.sv =====
// Shared constants and types for the minimum spanning tree core.
`timescale 1ns / 1ps

package mstk_pkg;

    // Fixed field widths.
    localparam int VTX_W = 6;
    localparam int VCNT_W = 7;
    localparam int SUM_W = 22;
    localparam int CHOSEN_W = 6;

    // At most this many tree edges are emitted per run.
    localparam logic [CHOSEN_W-1:0] CHOSEN_LIMIT = 6'd63;

    // Reset value of the vertex count register.
    localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

    // Default sizes.
    localparam int VERTEX_CAPACITY_DEF = 64;
    localparam int EDGE_CAPACITY_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    // Datapath operations, one per controller state.
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_INIT,
        OP_SKEY,
        OP_SKEYW,
        OP_SCMP,
        OP_SPUT,
        OP_EFETCH,
        OP_ELOAD,
        OP_FA,
        OP_FB,
        OP_UNION,
        OP_SUM
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic last_fire;
        logic init_done;
        logic idx_done;
        logic shift;
        logic j_last;
        logic in_range;
        logic root_hit;
        logic merge;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/mstk_ctrl.sv =====
// Controller state machine for the minimum spanning tree core.
`timescale 1ns / 1ps

module mstk_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mstk_pkg::t_status i_status,
    output mstk_pkg::t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_LOAD   = 12'b000000000001,
        S_INIT   = 12'b000000000010,
        S_SKEY   = 12'b000000000100,
        S_SKEYW  = 12'b000000001000,
        S_SCMP   = 12'b000000010000,
        S_SPUT   = 12'b000000100000,
        S_EFETCH = 12'b000001000000,
        S_ELOAD  = 12'b000010000000,
        S_FA     = 12'b000100000000,
        S_FB     = 12'b001000000000,
        S_UNION  = 12'b010000000000,
        S_SUM    = 12'b100000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:   if (i_status.last_fire) n_state = S_INIT;
            S_INIT:   if (i_status.init_done) n_state = S_SKEY;
            S_SKEY:   n_state = i_status.idx_done ? S_EFETCH : S_SKEYW;
            S_SKEYW:  n_state = S_SCMP;
            S_SCMP:   if (!i_status.shift || i_status.j_last) n_state = S_SPUT;
            S_SPUT:   n_state = S_SKEY;
            S_EFETCH: n_state = i_status.idx_done ? S_SUM : S_ELOAD;
            S_ELOAD:  n_state = i_status.in_range ? S_FA : S_EFETCH;
            S_FA:     if (i_status.root_hit) n_state = S_FB;
            S_FB:     if (i_status.root_hit) n_state = S_UNION;
            S_UNION:  if (!i_status.merge || i_status.out_free) n_state = S_EFETCH;
            S_SUM:    if (i_status.out_free) n_state = S_LOAD;
            default:  n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Operation issued to the datapath.
    always_comb begin
        case (r_state)
            S_LOAD:   o_cmd.op = mstk_pkg::OP_LOAD;
            S_INIT:   o_cmd.op = mstk_pkg::OP_INIT;
            S_SKEY:   o_cmd.op = mstk_pkg::OP_SKEY;
            S_SKEYW:  o_cmd.op = mstk_pkg::OP_SKEYW;
            S_SCMP:   o_cmd.op = mstk_pkg::OP_SCMP;
            S_SPUT:   o_cmd.op = mstk_pkg::OP_SPUT;
            S_EFETCH: o_cmd.op = mstk_pkg::OP_EFETCH;
            S_ELOAD:  o_cmd.op = mstk_pkg::OP_ELOAD;
            S_FA:     o_cmd.op = mstk_pkg::OP_FA;
            S_FB:     o_cmd.op = mstk_pkg::OP_FB;
            S_UNION:  o_cmd.op = mstk_pkg::OP_UNION;
            S_SUM:    o_cmd.op = mstk_pkg::OP_SUM;
            default:  o_cmd.op = mstk_pkg::OP_LOAD;
        endcase
    end

endmodule

// ===== rtl/mstk_dp.sv =====
// Datapath: edge store, parent store, counters and output register.
`timescale 1ns / 1ps

module mstk_dp #(
    parameter int VERTEX_CAPACITY = mstk_pkg::VERTEX_CAPACITY_DEF,
    parameter int EDGE_CAPACITY   = mstk_pkg::EDGE_CAPACITY_DEF,
    parameter int WEIGHT_BITS     = mstk_pkg::WEIGHT_BITS_DEF,
    localparam int IN_TW  = ((2 * mstk_pkg::VTX_W + WEIGHT_BITS + 7) / 8) * 8,
    localparam int OUT_TW = ((2 * mstk_pkg::VTX_W + WEIGHT_BITS + mstk_pkg::SUM_W + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mstk_pkg::t_cmd                    i_cmd,
    output mstk_pkg::t_status                 o_status,
    input  logic                              i_cfg_we,
    input  logic [mstk_pkg::VCNT_W-1:0]       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_TW-1:0]                  s_axis_tdata,
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_TW-1:0]                 m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int VW0  = mstk_pkg::VTX_W;
    localparam int EW   = 2 * VW0 + WEIGHT_BITS;
    localparam int EAW  = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
    localparam int CW   = $clog2(EDGE_CAPACITY + 1);
    localparam int MAXC = (EDGE_CAPACITY > VERTEX_CAPACITY) ? EDGE_CAPACITY : VERTEX_CAPACITY;
    localparam int IW   = $clog2(MAXC + 1);
    localparam int VW   = $clog2(VERTEX_CAPACITY);
    localparam int LW   = (IW > mstk_pkg::VCNT_W) ? IW : mstk_pkg::VCNT_W;
    localparam int SW   = mstk_pkg::SUM_W;
    localparam int EXTW = (WEIGHT_BITS > SW) ? WEIGHT_BITS : SW;

    // Stores.
    logic [EW-1:0] r_emem [EDGE_CAPACITY];
    logic [VW-1:0] r_pmem [VERTEX_CAPACITY];
    logic [EW-1:0] r_erd;
    logic [VW-1:0] r_prd;

    logic           e_we;
    logic [EAW-1:0] e_waddr;
    logic [EAW-1:0] e_raddr;
    logic [EW-1:0]  e_wdata;
    logic           p_we;
    logic [VW-1:0]  p_waddr;
    logic [VW-1:0]  p_wdata;
    logic [VW-1:0]  p_raddr;

    // Control registers.
    logic [mstk_pkg::VCNT_W-1:0]   r_vc;
    logic [CW-1:0]                 r_count, n_count;
    logic [SW-1:0]                 r_sum, n_sum;
    logic                          r_drop, n_drop;
    logic [mstk_pkg::CHOSEN_W-1:0] r_chosen, n_chosen;
    logic [IW-1:0]                 r_i, n_i;
    logic [IW-1:0]                 r_j, n_j;
    logic                          r_m_valid, n_m_valid;

    // Payload registers.
    logic [EW-1:0]          r_key, n_key;
    logic [EW-1:0]          r_edge, n_edge;
    logic [VW-1:0]          r_x, n_x;
    logic [VW-1:0]          r_ra, n_ra;
    logic [VW-1:0]          r_rb, n_rb;
    logic [VW0-1:0]         r_o_src, n_o_src;
    logic [VW0-1:0]         r_o_dst, n_o_dst;
    logic [WEIGHT_BITS-1:0] r_o_w, n_o_w;
    logic [SW-1:0]          r_o_sum, n_o_sum;
    logic                   r_o_summ, n_o_summ;
    logic                   r_o_drop, n_o_drop;

    logic                   s_fire;
    logic                   out_free;
    logic [LW-1:0]          nv;
    logic [LW-1:0]          ea_x, eb_x, ga_x, gb_x;
    logic [EXTW-1:0]        w_ext;
    logic [SW-1:0]          sum_add;
    logic [IW-1:0]          i_m1, j_m1, j_m2;

    // Effective vertex count, clamped to the capacity.
    always_comb begin
        if (LW'(r_vc) > LW'(VERTEX_CAPACITY)) nv = LW'(VERTEX_CAPACITY);
        else nv = LW'(r_vc);
    end

    assign s_axis_tready = (i_cmd.op == mstk_pkg::OP_LOAD);
    assign s_fire        = s_axis_tready && s_axis_tvalid;
    assign out_free      = !r_m_valid || m_axis_tready;

    // Endpoints of the fetched edge and of the edge under test.
    assign ea_x = LW'(r_erd[VW0-1:0]);
    assign eb_x = LW'(r_erd[2*VW0-1:VW0]);
    assign ga_x = LW'(r_edge[VW0-1:0]);
    assign gb_x = LW'(r_edge[2*VW0-1:VW0]);

    assign w_ext   = EXTW'($signed(r_edge[EW-1:2*VW0]));
    assign sum_add = r_sum + w_ext[SW-1:0];
    assign i_m1    = r_i - IW'(1);
    assign j_m1    = r_j - IW'(1);
    assign j_m2    = r_j - IW'(2);

    // Status back to the controller.
    always_comb begin
        o_status.last_fire = s_fire && s_axis_tlast;
        o_status.init_done = LW'(r_i) >= nv;
        o_status.idx_done  = LW'(r_i) >= LW'(r_count);
        o_status.shift     = $signed(r_erd[EW-1:2*VW0]) > $signed(r_key[EW-1:2*VW0]);
        o_status.j_last    = (r_j == IW'(1));
        o_status.in_range  = (ea_x < nv) && (eb_x < nv);
        o_status.root_hit  = (r_prd == r_x);
        o_status.merge     = (r_ra != r_rb) && (r_chosen != mstk_pkg::CHOSEN_LIMIT);
        o_status.out_free  = out_free;
    end

    // Operation decode.
    always_comb begin
        n_count   = r_count;
        n_sum     = r_sum;
        n_drop    = r_drop;
        n_chosen  = r_chosen;
        n_i       = r_i;
        n_j       = r_j;
        n_key     = r_key;
        n_edge    = r_edge;
        n_x       = r_x;
        n_ra      = r_ra;
        n_rb      = r_rb;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_o_src   = r_o_src;
        n_o_dst   = r_o_dst;
        n_o_w     = r_o_w;
        n_o_sum   = r_o_sum;
        n_o_summ  = r_o_summ;
        n_o_drop  = r_o_drop;
        e_we      = 1'b0;
        e_waddr   = r_count[EAW-1:0];
        e_wdata   = s_axis_tdata[EW-1:0];
        e_raddr   = r_i[EAW-1:0];
        p_we      = 1'b0;
        p_waddr   = r_i[VW-1:0];
        p_wdata   = r_i[VW-1:0];
        p_raddr   = r_prd;
        case (i_cmd.op)
            mstk_pkg::OP_LOAD: begin
                if (s_fire) begin
                    if (s_axis_tuser) begin
                        if (r_count != CW'(EDGE_CAPACITY)) begin
                            e_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    if (s_axis_tlast) n_i = '0;
                end
            end
            mstk_pkg::OP_INIT: begin
                // Every vertex starts as its own root.
                if (!o_status.init_done) begin
                    p_we = 1'b1;
                    n_i  = r_i + IW'(1);
                end else begin
                    n_i = IW'(1);
                end
            end
            mstk_pkg::OP_SKEY: begin
                if (o_status.idx_done) n_i = '0;
            end
            mstk_pkg::OP_SKEYW: begin
                n_key   = r_erd;
                n_j     = r_i;
                e_raddr = i_m1[EAW-1:0];
            end
            mstk_pkg::OP_SCMP: begin
                // Shift a heavier entry up by one place.
                if (o_status.shift) begin
                    e_we    = 1'b1;
                    e_waddr = r_j[EAW-1:0];
                    e_wdata = r_erd;
                    n_j     = j_m1;
                    e_raddr = j_m2[EAW-1:0];
                end
            end
            mstk_pkg::OP_SPUT: begin
                e_we    = 1'b1;
                e_waddr = r_j[EAW-1:0];
                e_wdata = r_key;
                n_i     = r_i + IW'(1);
            end
            mstk_pkg::OP_EFETCH: begin
                e_raddr = r_i[EAW-1:0];
            end
            mstk_pkg::OP_ELOAD: begin
                if (o_status.in_range) begin
                    n_edge  = r_erd;
                    n_x     = ea_x[VW-1:0];
                    p_raddr = ea_x[VW-1:0];
                end else begin
                    n_drop = 1'b1;
                    n_i    = r_i + IW'(1);
                end
            end
            mstk_pkg::OP_FA: begin
                if (o_status.root_hit) begin
                    n_ra    = r_x;
                    n_x     = gb_x[VW-1:0];
                    p_raddr = gb_x[VW-1:0];
                end else begin
                    n_x     = r_prd;
                    p_raddr = r_prd;
                end
            end
            mstk_pkg::OP_FB: begin
                if (o_status.root_hit) begin
                    n_rb = r_x;
                end else begin
                    n_x     = r_prd;
                    p_raddr = r_prd;
                end
            end
            mstk_pkg::OP_UNION: begin
                // Join two sets and emit the edge, or skip it.
                if (o_status.merge) begin
                    if (out_free) begin
                        p_we      = 1'b1;
                        p_waddr   = r_ra;
                        p_wdata   = r_rb;
                        n_sum     = sum_add;
                        n_chosen  = r_chosen + mstk_pkg::CHOSEN_W'(1);
                        n_i       = r_i + IW'(1);
                        n_m_valid = 1'b1;
                        n_o_src   = ga_x[VW0-1:0];
                        n_o_dst   = gb_x[VW0-1:0];
                        n_o_w     = r_edge[EW-1:2*VW0];
                        n_o_sum   = sum_add;
                        n_o_summ  = 1'b0;
                        n_o_drop  = 1'b0;
                    end
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            mstk_pkg::OP_SUM: begin
                // Closing summary item; clear the run state.
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_o_src   = '0;
                    n_o_dst   = '0;
                    n_o_w     = '0;
                    n_o_sum   = r_sum;
                    n_o_summ  = 1'b1;
                    n_o_drop  = r_drop;
                    n_count   = '0;
                    n_sum     = '0;
                    n_drop    = 1'b0;
                    n_chosen  = '0;
                    n_i       = '0;
                end
            end
            default: begin
                n_i = r_i;
            end
        endcase
    end

    // Edge store.
    always_ff @(posedge i_clk) begin
        if (e_we) r_emem[e_waddr] <= e_wdata;
        r_erd <= r_emem[e_raddr];
    end

    // Parent store.
    always_ff @(posedge i_clk) begin
        if (p_we) r_pmem[p_waddr] <= p_wdata;
        r_prd <= r_pmem[p_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc      <= mstk_pkg::VCNT_RESET;
            r_count   <= '0;
            r_sum     <= '0;
            r_drop    <= 1'b0;
            r_chosen  <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_vc <= i_cfg_wdata;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_drop    <= n_drop;
            r_chosen  <= n_chosen;
            r_i       <= n_i;
            r_j       <= n_j;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_edge   <= n_edge;
        r_x      <= n_x;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_o_src  <= n_o_src;
        r_o_dst  <= n_o_dst;
        r_o_w    <= n_o_w;
        r_o_sum  <= n_o_sum;
        r_o_summ <= n_o_summ;
        r_o_drop <= n_o_drop;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TW'({r_o_sum, r_o_w, r_o_dst, r_o_src});
    assign m_axis_tuser  = {r_o_drop, r_o_summ};
    assign m_axis_tlast  = r_o_summ;

endmodule

// ===== rtl/minimum_spanning_tree_kruskal_core.sv =====
// Top level of the Kruskal minimum spanning tree core.
`timescale 1ns / 1ps
// Usage:
// Edges enter on the slave stream, one item per cycle while s_axis_tready is
// high; tuser marks an item that carries an edge and tlast ends the graph.
// The vertex count register is written through i_cfg_we/i_cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce. After the
// last item the core stops taking input, fills the parent store (one vertex a
// cycle), insertion-sorts the edge store by ascending signed weight, then walks
// the sorted edges: for an edge in range it finds both ends' roots by following
// parent links and joins them if they differ, up to 63 joins; an edge out of range
// is skipped and flagged as dropped. Edge and parent memory reads are registered.
// Each chosen edge leaves on the master stream as an item; a summary item
// with tlast and the total weight closes the run, and loading resumes.
// The output register holds an item until m_axis_tready; a stall simply
// pauses the walk. Reset clears the edge count, sums, flags and handshakes
// and sets the vertex count to 64; memory contents are not cleared.
module minimum_spanning_tree_kruskal_core #(
    parameter int VERTEX_CAPACITY = mstk_pkg::VERTEX_CAPACITY_DEF,
    parameter int EDGE_CAPACITY   = mstk_pkg::EDGE_CAPACITY_DEF,
    parameter int WEIGHT_BITS     = mstk_pkg::WEIGHT_BITS_DEF,
    localparam int IN_TW  = ((2 * mstk_pkg::VTX_W + WEIGHT_BITS + 7) / 8) * 8,
    localparam int OUT_TW = ((2 * mstk_pkg::VTX_W + WEIGHT_BITS + mstk_pkg::SUM_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mstk_pkg::VCNT_W-1:0] i_cfg_wdata,   // vertex_count
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [IN_TW-1:0]            s_axis_tdata,  // src_vertex, dst_vertex, edge_weight
    input  logic                        s_axis_tuser,  // edge_valid
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_TW-1:0]           m_axis_tdata,  // tree_src, tree_dst, tree_edge_weight,
                                                       // total_weight
    output logic [1:0]                  m_axis_tuser,  // is_summary, edges_dropped
    output logic                        m_axis_tlast
);

    mstk_pkg::t_cmd    cmd;
    mstk_pkg::t_status status;

    mstk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mstk_dp #(
        .VERTEX_CAPACITY (VERTEX_CAPACITY),
        .EDGE_CAPACITY   (EDGE_CAPACITY),
        .WEIGHT_BITS     (WEIGHT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // The last input item starts a run, so input closes right after it.
    a_last_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after the last item");

    // Only the summary item ends a run.
    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]))
        else $error("tlast does not match the summary flag");

    // The dropped flag shows only on a summary item.
    a_drop_on_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("dropped flag on a tree edge item");
`endif

endmodule
